// File: rtl/tilt_angle_smoother_with_hold_top_macros.svh
// Assertion helpers for the top-level RTL file, which checks its own logic.
`ifndef TILT_ANGLE_SMOOTHER_WITH_HOLD_TOP_MACROS_SVH
`define TILT_ANGLE_SMOOTHER_WITH_HOLD_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TASM_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TASM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/tasm_pkg.sv
package tasm_pkg;

  // Angle width in 1/256 degree, CORDIC datapath and angle accumulator widths.
  localparam int AW = 17;
  localparam int CW = 32;
  localparam int ZW = AW + 8;
  localparam int IN_SHIFT = 12;

  // CORDIC iteration count, capped by the arctangent table depth.
  localparam int CORDIC_STEPS = 16;
  localparam int MAX_STEPS = 24;
  localparam int NSTEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int STEP_W = $clog2(MAX_STEPS);

  // Clamp and filter constants.
  localparam logic [15:0] FULL_LIMIT = 16'd46080;
  localparam logic [16:0] GAIN_ONE = 17'd65536;
  localparam int PW = 36;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GAIN = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;
  localparam logic [1:0] CFG_POPUP = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [16:0] GAIN_RESET = 17'd6554;
  localparam logic [15:0] LIMIT_RESET = 16'd11520;
  localparam logic [15:0] POPUP_RESET = 16'd5000;

  // atan(2^-i) in degrees, Q16.
  localparam logic [21:0] ATAN_TAB [MAX_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  // Status returned by an arithmetic unit when its work is finished.
  typedef struct packed {
    logic                 done;
    logic signed [AW-1:0] value;
  } unit_st_t;

endpackage

// File: rtl/tasm_if.sv
// Input channel: one accelerometer sample with lock level and time.
interface tasm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic               lock_pressed;
  logic [31:0]        now_ms;

  modport source (output valid, accel_x, accel_y, accel_z, lock_pressed, now_ms,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, lock_pressed, now_ms,
                output ready);
endinterface

// Output channel: smoothed and held angles with lock and popup flags.
interface tasm_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] roll_angle;
  logic signed [16:0] pitch_angle;
  logic signed [16:0] held_roll;
  logic signed [16:0] held_pitch;
  logic               locked;
  logic               popup_on;

  modport source (output valid, roll_angle, pitch_angle, held_roll, held_pitch, locked,
                  popup_on, input ready);
  modport sink (input valid, roll_angle, pitch_angle, held_roll, held_pitch, locked,
                popup_on, output ready);
endinterface

// File: rtl/tasm_cordic.sv
module tasm_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [tasm_pkg::AW-1:0] num_i,
  input  logic signed [tasm_pkg::AW-1:0] den_i,
  input  logic [15:0]                    limit_i,
  output tasm_pkg::unit_st_t             st_o
);
  import tasm_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ITER = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;

  localparam logic signed [ZW-1:0] ANG90 = ZW'(90 * 65536);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

  logic [1:0]              ph_q, ph_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    done_q, done_d;
  logic signed [CW-1:0]    x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]    z_q, z_d;
  logic                    zero_q, zero_d;
  logic signed [AW-1:0]    angle_q, angle_d;

  logic signed [CW-1:0]    num_w, den_w, dx, dy;
  logic signed [ZW-1:0]    atan_w, z_rnd;
  logic signed [AW-1:0]    raw, lim_s;
  logic [15:0]             lim;

  // Shared shifters and arctangent lookup for the current step.
  assign num_w  = CW'(num_i);
  assign den_w  = CW'(den_i);
  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign atan_w = $signed({3'b000, ATAN_TAB[step_q]});

  // Round the accumulator to 1/256 degree and clamp to the limit.
  assign z_rnd = z_q + ZW'(128);
  assign raw   = z_rnd[ZW-1:8];
  assign lim   = (limit_i > FULL_LIMIT) ? FULL_LIMIT : limit_i;
  assign lim_s = $signed({1'b0, lim});

  // Sequencer and rotation step.
  always_comb begin
    ph_d    = ph_q;
    step_d  = step_q;
    done_d  = 1'b0;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    zero_d  = zero_q;
    angle_d = angle_q;
    unique case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          ph_d   = PH_ITER;
          step_d = '0;
          zero_d = (num_i == '0) && (den_i == '0);
          if (num_i > 0) begin
            x_d = num_w <<< IN_SHIFT;
            y_d = (-den_w) <<< IN_SHIFT;
            z_d = ANG90;
          end else begin
            x_d = (-num_w) <<< IN_SHIFT;
            y_d = den_w <<< IN_SHIFT;
            z_d = -ANG90;
          end
        end
      end
      PH_ITER: begin
        if (y_q > 0) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_w;
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_w;
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          ph_d = PH_FIN;
        end
      end
      PH_FIN: begin
        ph_d   = PH_IDLE;
        done_d = 1'b1;
        priority if (zero_q) begin
          angle_d = '0;
        end else if (raw > lim_s) begin
          angle_d = lim_s;
        end else if (raw < -lim_s) begin
          angle_d = -lim_s;
        end else begin
          angle_d = raw;
        end
      end
      default: begin
        ph_d = PH_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    zero_q  <= zero_d;
    angle_q <= angle_d;
  end

  assign st_o.done  = done_q;
  assign st_o.value = angle_q;

endmodule

// File: rtl/tasm_mac.sv
module tasm_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [tasm_pkg::AW-1:0] raw_i,
  input  logic signed [tasm_pkg::AW-1:0] prev_i,
  input  logic [16:0]                    gain_i,
  output tasm_pkg::unit_st_t             st_o
);
  import tasm_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_M1   = 2'd1;
  localparam logic [1:0] PH_M2   = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [1:0]              ph_q, ph_d;
  logic                    done_q;
  logic signed [AW-1:0]    raw_q, prev_q, res_q;
  logic signed [PW-1:0]    prod_q, acc_q, sum;
  logic [16:0]             g, g_inv;
  logic signed [17:0]      op_a;
  logic signed [AW-1:0]    op_b;
  logic signed [AW+17:0]   prod;

  // Gain saturates at one; the old value takes the complement.
  assign g     = (gain_i > GAIN_ONE) ? GAIN_ONE : gain_i;
  assign g_inv = GAIN_ONE - g;

  // One shared multiplier: new sample first, then the previous output.
  assign op_a = (ph_q == PH_M1) ? $signed({1'b0, g}) : $signed({1'b0, g_inv});
  assign op_b = (ph_q == PH_M1) ? raw_q : prev_q;
  assign prod = op_a * op_b;
  assign sum  = acc_q + prod_q + PW'(32768);

  // Phase sequencer.
  always_comb begin
    unique case (ph_q)
      PH_IDLE: ph_d = start_i ? PH_M1 : PH_IDLE;
      PH_M1:   ph_d = PH_M2;
      PH_M2:   ph_d = PH_FIN;
      PH_FIN:  ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= (ph_q == PH_FIN);
    end
  end

  // Operand latches, product register, accumulator and result.
  always_ff @(posedge clk_i) begin
    if (ph_q == PH_IDLE && start_i) begin
      raw_q  <= raw_i;
      prev_q <= prev_i;
    end
    if (ph_q == PH_M1 || ph_q == PH_M2) begin
      prod_q <= PW'(prod);
    end
    if (ph_q == PH_M2) begin
      acc_q <= prod_q;
    end
    if (ph_q == PH_FIN) begin
      res_q <= sum[AW+15:16];
    end
  end

  assign st_o.done  = done_q;
  assign st_o.value = res_q;

endmodule

// File: rtl/tilt_angle_smoother_with_hold_top.sv
// Channel   | Direction | Moves per transaction
// in_i      | sink      | accel_x, accel_y, accel_z, lock_pressed, now_ms
// out_o     | source    | roll_angle, pitch_angle, held_roll, held_pitch, locked, popup_on
// cfg_*     | write     | smoothing_gain, angle_limit, popup_duration_ms
//
// A sample is accepted only while the sequencer idles, so the next one waits until the result
// of the previous one is loaded: two rotator passes (start, CORDIC_STEPS iterations, rounding),
// two filter passes, and the start and output steps of the sequencer.
// Reset clears the filter, hold and popup state at once; there is no clearing pass.
// A finished result sits in the output register; while it is not taken, the next
// sample may still be accepted, and the sequencer waits only at its final step.
module tilt_angle_smoother_with_hold_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  tasm_in_if.sink     in_i,
  tasm_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);
  import tasm_pkg::*;
  `include "tilt_angle_smoother_with_hold_top_macros.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_ROLL   = 3'd2;
  localparam logic [2:0] S_PITCH  = 3'd3;
  localparam logic [2:0] S_FROLL  = 3'd4;
  localparam logic [2:0] S_FPITCH = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]           state_q, state_d;

  // Configuration registers.
  logic [16:0]          gain_q;
  logic [15:0]          limit_q;
  logic [15:0]          popup_q;

  // Latched sample.
  logic signed [15:0]   ax_q, ay_q, az_q;
  logic                 lock_q;
  logic [31:0]          now_q;

  // Intermediate results.
  logic signed [AW-1:0] raw_roll_q, raw_pitch_q, new_roll_q, new_pitch_q;

  // Block state.
  logic signed [AW-1:0] roll_f_q, pitch_f_q, roll_c_q, pitch_c_q;
  logic                 lock_prev_q;
  logic [31:0]          deadline_q;

  // Output register.
  logic                 out_valid_q;
  logic signed [AW-1:0] o_roll_q, o_pitch_q, o_hroll_q, o_hpitch_q;
  logic                 o_locked_q, o_show_q;

  unit_st_t             cor_st, mac_st;
  logic                 cor_start, mac_start, accept, emit;
  logic signed [AW-1:0] cor_num, cor_den, mac_raw, mac_prev;
  logic                 release_w, show_w;
  logic [31:0]          deadline_w;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign emit = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // Operand selection for the rotator: roll uses -y, pitch uses -x, both over -z.
  assign cor_start = (state_q == S_START) || (state_q == S_ROLL && cor_st.done);
  assign cor_num   = (state_q == S_START) ? -AW'(ay_q) : -AW'(ax_q);
  assign cor_den   = -AW'(az_q);

  // Operand selection for the filter unit.
  assign mac_start = (state_q == S_PITCH && cor_st.done) ||
                     (state_q == S_FROLL && mac_st.done);
  assign mac_raw   = (state_q == S_PITCH) ? raw_roll_q : raw_pitch_q;
  assign mac_prev  = (state_q == S_PITCH) ? roll_f_q : pitch_f_q;

  tasm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .num_i   (cor_num),
    .den_i   (cor_den),
    .limit_i (limit_q),
    .st_o    (cor_st)
  );

  tasm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .raw_i   (mac_raw),
    .prev_i  (mac_prev),
    .gain_i  (gain_q),
    .st_o    (mac_st)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_START;
      S_START:  state_d = S_ROLL;
      S_ROLL:   if (cor_st.done) state_d = S_PITCH;
      S_PITCH:  if (cor_st.done) state_d = S_FROLL;
      S_FROLL:  if (mac_st.done) state_d = S_FPITCH;
      S_FPITCH: if (mac_st.done) state_d = S_OUT;
      S_OUT:    if (emit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Lock release captures the angles and arms the popup deadline.
  assign release_w  = lock_prev_q && !lock_q;
  assign deadline_w = release_w ? (now_q + {16'd0, popup_q}) : deadline_q;
  assign show_w     = (deadline_w != '0) && !lock_q && (now_q < deadline_w);

  // Control state, configuration and block state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_q      <= GAIN_RESET;
      limit_q     <= LIMIT_RESET;
      popup_q     <= POPUP_RESET;
      roll_f_q    <= '0;
      pitch_f_q   <= '0;
      roll_c_q    <= '0;
      pitch_c_q   <= '0;
      lock_prev_q <= 1'b0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GAIN:  gain_q  <= cfg_data_i;
          CFG_LIMIT: limit_q <= cfg_data_i[15:0];
          CFG_POPUP: popup_q <= cfg_data_i[15:0];
          default:   ;
        endcase
      end
      if (emit) begin
        roll_f_q    <= new_roll_q;
        pitch_f_q   <= new_pitch_q;
        if (release_w) begin
          roll_c_q  <= new_roll_q;
          pitch_c_q <= new_pitch_q;
        end
        lock_prev_q <= lock_q;
        deadline_q  <= show_w ? deadline_w : '0;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q   <= in_i.accel_x;
      ay_q   <= in_i.accel_y;
      az_q   <= in_i.accel_z;
      lock_q <= in_i.lock_pressed;
      now_q  <= in_i.now_ms;
    end
    if (state_q == S_ROLL && cor_st.done) raw_roll_q <= cor_st.value;
    if (state_q == S_PITCH && cor_st.done) raw_pitch_q <= cor_st.value;
    if (state_q == S_FROLL && mac_st.done) new_roll_q <= mac_st.value;
    if (state_q == S_FPITCH && mac_st.done) new_pitch_q <= mac_st.value;
    if (emit) begin
      o_roll_q   <= new_roll_q;
      o_pitch_q  <= new_pitch_q;
      o_hroll_q  <= release_w ? new_roll_q : roll_c_q;
      o_hpitch_q <= release_w ? new_pitch_q : pitch_c_q;
      o_locked_q <= lock_q;
      o_show_q   <= show_w;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.roll_angle  = o_roll_q;
  assign out_o.pitch_angle = o_pitch_q;
  assign out_o.held_roll   = o_hroll_q;
  assign out_o.held_pitch  = o_hpitch_q;
  assign out_o.locked      = o_locked_q;
  assign out_o.popup_on    = o_show_q;

  // The rotator and the filter unit never finish in the same cycle.
  `TASM_ASSERT_NOW(a_units_apart, cor_st.done, !mac_st.done, "rotator and filter both done")
  // A result leaves the final step into the output register and the sequencer idles.
  `TASM_ASSERT_NEXT(a_emit_loads, emit, out_valid_q && state_q == S_IDLE, "result not loaded")
  // A shown popup never coexists with a held lock button.
  `TASM_ASSERT_NOW(a_popup_unlocked, out_valid_q && o_show_q, !o_locked_q, "popup while locked")
  // With no popup shown, the deadline has been cleared.
  `TASM_ASSERT_NOW(a_deadline_clear, out_valid_q && !o_show_q, deadline_q == '0,
                   "deadline left armed without popup")

endmodule

// File: verif/tb_tilt_angle_smoother_with_hold_top.sv
module tb_tilt_angle_smoother_with_hold_top;

  // One accelerometer sample as offered on the input channel.
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               lock;
    logic [31:0]        now;
  } tilt_sample_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
    logic signed [16:0] held_roll;
    logic signed [16:0] held_pitch;
    logic               locked;
    logic               popup;
  } tilt_result_t;

  // A directed row: the sample, and where known by inspection, its result.
  typedef struct packed {
    tilt_sample_t sample;
    logic         typed;
    tilt_result_t want;
  } tilt_row_t;

  localparam int ROT_STEPS = 16;
  localparam int ANGLE_MAX = 46080;
  localparam longint UNITY_GAIN = 65536;

  // Arctangent of 2^-i in degrees, Q16.
  localparam longint ATAN_DEG_Q16 [ROT_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  localparam logic signed [15:0] AXIS_EXTREMES [5] = '{-32768, -1, 0, 1, 32767};

  localparam int N_DIRECTED = 23;

  // Directed rows run with unity gain, a 45 degree limit and a 5000 ms popup.
  // With unity gain the smoothed angle equals the clamped raw angle, so rows
  // that land on the clamp or on an exact zero are typed in directly.
  tilt_row_t directed_rows [N_DIRECTED] = '{
    '{'{0, 0, 0, 1'b0, 32'd0}, 1'b1, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{0, 0, 32767, 1'b1, 32'd10}, 1'b1, '{-11520, -11520, 0, 0, 1'b1, 1'b0}},
    '{'{0, 0, 32767, 1'b0, 32'd20}, 1'b1,
      '{-11520, -11520, -11520, -11520, 1'b0, 1'b1}},
    '{'{32767, 0, 0, 1'b0, 32'd5019}, 1'b1, '{0, -11520, -11520, -11520, 1'b0, 1'b1}},
    '{'{-32768, 0, 0, 1'b0, 32'd5020}, 1'b1, '{0, 11520, -11520, -11520, 1'b0, 1'b0}},
    '{'{0, -32768, 0, 1'b1, 32'd6000}, 1'b1, '{11520, 0, -11520, -11520, 1'b1, 1'b0}},
    '{'{0, 32767, 0, 1'b1, 32'd6001}, 1'b1, '{-11520, 0, -11520, -11520, 1'b1, 1'b0}},
    '{'{-32768, -32768, -32768, 1'b1, 32'd7000}, 1'b0, '0},
    '{'{32767, 32767, 32767, 1'b0, 32'd7001}, 1'b0, '0},
    '{'{1, -1, 0, 1'b0, 32'd7001}, 1'b0, '0},
    '{'{0, 0, -1, 1'b0, 32'd7002}, 1'b0, '0},
    '{'{0, 0, 1, 1'b1, 32'd7003}, 1'b0, '0},
    '{'{100, -200, 16384, 1'b1, 32'hFFFF_F000}, 1'b0, '0},
    '{'{-100, 200, 16384, 1'b0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{5, 5, -16384, 1'b1, 32'hFFFF_EC78}, 1'b0, '0},
    '{'{5, 5, -16384, 1'b0, 32'hFFFF_EC78}, 1'b0, '0},
    '{'{0, 16384, 16384, 1'b1, 32'd100}, 1'b0, '0},
    '{'{0, 16384, 16384, 1'b0, 32'd200}, 1'b0, '0},
    '{'{0, -16384, 16384, 1'b1, 32'd300}, 1'b0, '0},
    '{'{0, -16384, 16384, 1'b0, 32'd400}, 1'b0, '0},
    '{'{32767, -32768, 1, 1'b0, 32'd401}, 1'b0, '0},
    '{'{-1, -1, -1, 1'b0, 32'd5399}, 1'b0, '0},
    '{'{16384, 0, -16384, 1'b0, 32'd5400}, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [16:0] cfg_data_i;

  tasm_in_if  in_if ();
  tasm_out_if out_if ();

  tilt_angle_smoother_with_hold_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the configuration registers.
  logic [16:0] gain_reg;
  logic [15:0] limit_reg;
  logic [15:0] popup_reg;

  // Predicted filter, hold and popup state.
  logic signed [16:0] roll_flt;
  logic signed [16:0] pitch_flt;
  logic signed [16:0] roll_held;
  logic signed [16:0] pitch_held;
  logic               lock_prev;
  logic [31:0]        popup_deadline;

  // Results still owed by the block, oldest first.
  tilt_result_t pending_angles [$];

  // Random sample generator state: a running clock and a lock level.
  logic [31:0] sim_now;
  logic        sim_lock;

  int src_idle_pct;
  int snk_stall_pct;
  int hold_off_cycles;
  int n_samples;
  int n_writes;
  int n_releases;
  int n_popups;
  int n_mismatches;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit, several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Vectoring CORDIC: atan2(num, den) in 1/256 degree.
  function automatic int cordic_angle(input longint num, input longint den);
    longint x, y, z, dx, dy;
    if (num == 0 && den == 0) return 0;
    if (num > 0) begin
      x = num * 4096;
      y = -den * 4096;
      z = 90 * 65536;
    end else begin
      x = -num * 4096;
      y = den * 4096;
      z = -90 * 65536;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_DEG_Q16[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_DEG_Q16[i];
      end
    end
    return int'((z + 128) >>> 8);
  endfunction

  function automatic int clamp_angle(input int a);
    int lim;
    lim = (limit_reg > 16'd46080) ? ANGLE_MAX : int'(limit_reg);
    if (a > lim) return lim;
    if (a < -lim) return -lim;
    return a;
  endfunction

  // First-order low-pass step; gains above one act as one.
  function automatic int smooth_step(input int prev, input int raw);
    longint g, acc;
    g = (gain_reg > 17'd65536) ? UNITY_GAIN : longint'(gain_reg);
    acc = g * longint'(raw) + (UNITY_GAIN - g) * longint'(prev) + 32768;
    return int'(acc >>> 16);
  endfunction

  // Advances the predicted state by one sample and returns its result.
  function automatic tilt_result_t tilt_predict(input tilt_sample_t s);
    tilt_result_t r;
    int           roll_raw;
    int           pitch_raw;
    logic         show;
    roll_raw = clamp_angle(cordic_angle(-longint'(s.ay), -longint'(s.az)));
    pitch_raw = clamp_angle(cordic_angle(-longint'(s.ax), -longint'(s.az)));
    roll_flt = 17'(smooth_step(int'(roll_flt), roll_raw));
    pitch_flt = 17'(smooth_step(int'(pitch_flt), pitch_raw));
    // Release of the lock captures the angles and arms the popup.
    if (lock_prev && !s.lock) begin
      roll_held = roll_flt;
      pitch_held = pitch_flt;
      popup_deadline = s.now + 32'(popup_reg);
      n_releases++;
    end
    lock_prev = s.lock;
    show = (popup_deadline != 32'd0) && !s.lock && (s.now < popup_deadline);
    if (!show) popup_deadline = '0;
    r.roll = roll_flt;
    r.pitch = pitch_flt;
    r.held_roll = roll_held;
    r.held_pitch = pitch_held;
    r.locked = s.lock;
    r.popup = show;
    return r;
  endfunction

  // Random sample: a clock that mostly creeps forward, a lock that toggles
  // now and then, and axis values drawn from several shapes.
  function automatic tilt_sample_t random_sample();
    tilt_sample_t s;
    case ($urandom_range(0, 19))
      0:       sim_now = $urandom;
      1:       sim_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 6000));
      default: sim_now = sim_now + 32'($urandom_range(0, 1500));
    endcase
    if ($urandom_range(0, 4) == 0) sim_lock = ~sim_lock;
    s.ax = 16'($urandom);
    s.ay = 16'($urandom);
    s.az = 16'($urandom);
    case ($urandom_range(0, 5))
      2: begin
        // Device held roughly level, either face up or face down.
        s.ax = 16'(int'($urandom_range(0, 8000)) - 4000);
        s.ay = 16'(int'($urandom_range(0, 8000)) - 4000);
        s.az = 16'(($urandom_range(0, 1) ? 16384 : -16384) +
                   int'($urandom_range(0, 2000)) - 1000);
      end
      3: begin
        s.ax = 16'(int'($urandom_range(0, 31)) - 16);
        s.ay = 16'(int'($urandom_range(0, 31)) - 16);
        s.az = 16'(int'($urandom_range(0, 31)) - 16);
      end
      4: begin
        // Zeroed axes reach the zero vector and the zero-numerator cases.
        case ($urandom_range(0, 3))
          0: begin s.ax = '0; s.ay = '0; end
          1: s.az = '0;
          2: begin s.ay = '0; s.az = '0; end
          default: begin s.ax = '0; s.ay = '0; s.az = '0; end
        endcase
      end
      5: begin
        s.ax = AXIS_EXTREMES[$urandom_range(0, 4)];
        s.ay = AXIS_EXTREMES[$urandom_range(0, 4)];
        s.az = AXIS_EXTREMES[$urandom_range(0, 4)];
      end
      default: ;
    endcase
    s.lock = sim_lock;
    s.now = sim_now;
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    n_mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic signed [16:0] got,
                             input logic signed [16:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic wait_drained();
    while (pending_angles.size() != 0) @(negedge clk_i);
  endtask

  // Register write, issued at a falling edge while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      tasm_pkg::CFG_GAIN:  gain_reg = data;
      tasm_pkg::CFG_LIMIT: limit_reg = data[15:0];
      tasm_pkg::CFG_POPUP: popup_reg = data[15:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Offers one sample, waits for the transaction and queues its result.
  // Starts and ends at a falling edge.
  task automatic offer_sample(input tilt_sample_t s, input logic typed,
                              input tilt_result_t want);
    tilt_result_t model;
    while ($urandom_range(0, 99) < src_idle_pct) @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.accel_x = s.ax;
    in_if.accel_y = s.ay;
    in_if.accel_z = s.az;
    in_if.lock_pressed = s.lock;
    in_if.now_ms = s.now;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    model = tilt_predict(s);
    pending_angles.push_back(typed ? want : model);
    n_samples++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // One configuration setting followed by a stretch of random samples.
  task automatic run_phase(input logic [16:0] gain, input logic [16:0] limit_w,
                           input logic [16:0] popup_w, input int src_pct,
                           input int snk_pct, input int count, input logic pressure);
    wait_drained();
    write_reg(tasm_pkg::CFG_GAIN, gain);
    write_reg(tasm_pkg::CFG_LIMIT, limit_w);
    write_reg(tasm_pkg::CFG_POPUP, popup_w);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < count; i++) begin
      // Long output hold-off while samples keep coming, then a full drain.
      if (pressure && i == 40) hold_off_cycles = 400;
      if (pressure && i == 150) wait_drained();
      offer_sample(random_sample(), 1'b0, '0);
    end
  endtask

  // Output side: random stalls, plus the long hold-off when requested.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_off_cycles--;
      end else begin
        out_if.ready = ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  // Each result transaction is compared with the oldest expected result.
  always @(posedge clk_i) begin : result_check
    tilt_result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("result with no sample outstanding");
      end else begin
        want = pending_angles.pop_front();
        check_field("roll_angle", out_if.roll_angle, want.roll);
        check_field("pitch_angle", out_if.pitch_angle, want.pitch);
        check_field("held_roll", out_if.held_roll, want.held_roll);
        check_field("held_pitch", out_if.held_pitch, want.held_pitch);
        check_field("locked", 17'(out_if.locked), 17'(want.locked));
        check_field("popup_on", 17'(out_if.popup_on), 17'(want.popup));
        if (out_if.popup_on === 1'b1) n_popups++;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tasm_pkg::CFG_GAIN;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.accel_x = '0;
    in_if.accel_y = '0;
    in_if.accel_z = '0;
    in_if.lock_pressed = 1'b0;
    in_if.now_ms = '0;
    gain_reg = 17'd6554;
    limit_reg = 16'd11520;
    popup_reg = 16'd5000;
    roll_flt = '0;
    pitch_flt = '0;
    roll_held = '0;
    pitch_held = '0;
    lock_prev = 1'b0;
    popup_deadline = '0;
    sim_now = '0;
    sim_lock = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_off_cycles = 0;
    n_samples = 0;
    n_writes = 0;
    n_releases = 0;
    n_popups = 0;
    n_mismatches = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed samples.
    write_reg(tasm_pkg::CFG_GAIN, 17'd65536);
    write_reg(tasm_pkg::CFG_LIMIT, 17'd11520);
    write_reg(tasm_pkg::CFG_POPUP, 17'd5000);
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random samples over a series of settings and idle patterns.
    run_phase(17'd6554, 17'd11520, 17'd5000, 0, 0, 250, 1'b0);
    run_phase(17'd0, 17'd46080, 17'd65535, 56, 0, 250, 1'b0);
    run_phase(17'h1FFFF, 17'd65535, 17'd0, 0, 56, 250, 1'b0);
    run_phase(17'($urandom), 17'($urandom), 17'($urandom), 11, 11, 250, 1'b0);
    run_phase(17'd1, 17'd0, 17'd1, 0, 0, 100, 1'b0);
    run_phase(17'd65536, 17'd46080, 17'($urandom_range(0, 3000)), 0, 11, 250, 1'b1);
    run_phase(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 46080)),
              17'($urandom_range(0, 8000)), 11, 11, 400, 1'b0);

    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("covered %0d samples across %0d register writes, %0d lock releases, %0d popups",
             n_samples, n_writes, n_releases, n_popups);
    $display("with input gaps, output stalls, a long output hold-off and a full drain");
    if (n_mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/tasm_pkg.sv
rtl/tasm_if.sv
rtl/tasm_cordic.sv
rtl/tasm_mac.sv
rtl/tilt_angle_smoother_with_hold_top.sv
verif/tb_tilt_angle_smoother_with_hold_top.sv
